@@ rtl/hrc_pkg.sv @@
// ============================================================================
// hrc_pkg: shared types and constants for the hashed route cache
// Holds the beat payload structs, command and status codes, and sizing.
// ============================================================================
package hrc_pkg;

    // Sizing of the cache and of one stored route.
    localparam int SLOTS     = 256;
    localparam int MAX_ROUTE = 32;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int RIDX_W    = $clog2(MAX_ROUTE);
    localparam int SCNT_W    = $clog2(MAX_ROUTE + 2);
    localparam int RS_AW     = $clog2(SLOTS * MAX_ROUTE);
    localparam int LEN_W     = 6;
    localparam int CNT_W     = 9;

    // Golden-ratio multiplier split into 32-bit halves.
    localparam logic [31:0] GOLD_HI = 32'h9e37_79b9;
    localparam logic [31:0] GOLD_LO = 32'h7f4a_7c15;
    localparam logic [31:0] NO_NODE = 32'hffff_ffff;
    // The slot is taken from product bits 57..50, i.e. from bit 18 of the top word.
    localparam int HASH_LSB = 18;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_FILL   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_TRIVIAL  = 3'd1;
    localparam logic [2:0] ST_MISS     = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_STORED   = 3'd4;
    localparam logic [2:0] ST_TOO_LONG = 3'd5;
    localparam logic [2:0] ST_CLEARED  = 3'd6;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] start_node;
        logic [31:0] goal_node;
        logic        car;
        logic [31:0] route_node;
        logic        fill_last;
    } t_in;

    typedef struct packed {
        logic [31:0]      out_node;
        logic [LEN_W-1:0] route_length;
        logic [2:0]       status;
        logic             last;
        logic [CNT_W-1:0] entries_in_use;
    } t_out;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        t_in               item;
        logic [SLOT_W-1:0] slot;
    } t_job;

    // The 64-bit key; the top bit of the start node falls off.
    function automatic logic [63:0] key_of(input t_in it);
        return {it.start_node[30:0], it.goal_node, it.car};
    endfunction

    function automatic t_out mk_out(input logic [31:0] node, input logic [LEN_W-1:0] len,
                                    input logic [2:0] status, input logic last,
                                    input logic [CNT_W-1:0] filled);
        t_out r;
        r.out_node       = node;
        r.route_length   = len;
        r.status         = status;
        r.last           = last;
        r.entries_in_use = filled;
        return r;
    endfunction

endpackage

@@ rtl/hrc_front.sv @@
// ============================================================================
// hrc_front: input stage of the hashed route cache
// Accepts one beat, forms the key hash with a shared 32x32 multiplier in the
// states M0, M1 and M2 and hands the item with its slot to the queue.
// ============================================================================
module hrc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  hrc_pkg::t_in  i_data,
    output logic          o_push,
    input  logic          i_full,
    output hrc_pkg::t_job o_job
);
    import hrc_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_M0, F_M1, F_M2, F_PUSH} t_fst;

    t_fst        r_st;
    t_in         r_item;
    logic [31:0] r_hi;
    logic [63:0] w_key;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [63:0] w_prod;

    assign w_key = key_of(r_item);

    // Operand selection for the three partial products of the low 64 bits.
    always_comb begin
        case (r_st)
            F_M1: begin
                w_a = w_key[63:32];
                w_b = GOLD_LO;
            end
            F_M2: begin
                w_a = w_key[31:0];
                w_b = GOLD_HI;
            end
            default: begin
                w_a = w_key[31:0];
                w_b = GOLD_LO;
            end
        endcase
    end

    assign w_prod = 64'(w_a) * 64'(w_b);

    // Sequencer and the upper product word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= F_IDLE;
        end else begin
            case (r_st)
                F_IDLE: begin
                    if (i_valid) begin
                        r_item <= i_data;
                        r_st   <= F_M0;
                    end
                end
                F_M0: begin
                    r_hi <= w_prod[63:32];
                    r_st <= F_M1;
                end
                F_M1: begin
                    r_hi <= r_hi + w_prod[31:0];
                    r_st <= F_M2;
                end
                F_M2: begin
                    r_hi <= r_hi + w_prod[31:0];
                    r_st <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_st <= F_IDLE;
                    end
                end
                default: r_st <= F_IDLE;
            endcase
        end
    end

    assign o_stall    = (r_st != F_IDLE);
    assign o_push     = (r_st == F_PUSH);
    assign o_job.item = r_item;
    assign o_job.slot = r_hi[HASH_LSB +: SLOT_W];

endmodule

@@ rtl/hrc_fifo.sv @@
// ============================================================================
// hrc_fifo: two-entry queue between front and back
// Lets the front classify the next item while the back is still busy.
// ============================================================================
module hrc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hrc_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output hrc_pkg::t_job o_job
);
    import hrc_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;
    assign o_job   = r_mem[r_rp];

    // Storage and pointers.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (w_rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule

@@ rtl/hrc_back.sv @@
// ============================================================================
// hrc_back: execution stage of the hashed route cache
// Holds the slot tables, route store and staging buffer, runs lookups,
// fills and clears, and drives the registered result beat.
// ============================================================================
module hrc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_jv,
    input  hrc_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output hrc_pkg::t_out o_data
);
    import hrc_pkg::*;

    typedef enum logic [2:0] {B_IDLE, B_LOOK, B_SRD, B_SWR, B_CRD, B_CWR, B_OUT} t_bst;

    t_bst              r_st;
    t_job              r_job;
    logic [SLOTS-1:0]  r_valid;
    logic [CNT_W-1:0]  r_filled;
    logic [SCNT_W-1:0] r_scnt;
    logic [SCNT_W-1:0] r_len;
    logic [SCNT_W-1:0] r_idx;
    t_out              r_res;
    t_out              r_out;
    logic              r_ov;

    // Memories and their registered read data.
    logic [63:0]       m_key   [SLOTS];
    logic [SCNT_W-1:0] m_len   [SLOTS];
    logic [31:0]       m_route [SLOTS * MAX_ROUTE];
    logic [31:0]       m_stage [MAX_ROUTE];
    logic [63:0]       r_key_q;
    logic [SCNT_W-1:0] r_len_q;
    logic [31:0]       r_route_q;
    logic [31:0]       r_stage_q;

    logic              w_bad;
    logic              w_triv;
    logic [SCNT_W-1:0] w_scnt_inc;
    logic              w_out_free;
    logic              w_load;
    logic              w_idx_last;
    logic [RS_AW-1:0]  w_rs_addr;
    logic              w_stage_we;
    logic              w_commit;
    logic              w_hit;
    logic [CNT_W-1:0]  w_filled_new;

    assign w_bad  = (i_job.item.start_node == NO_NODE) || (i_job.item.goal_node == NO_NODE);
    assign w_triv = (i_job.item.start_node == i_job.item.goal_node);
    assign w_scnt_inc = (r_scnt <= SCNT_W'(MAX_ROUTE)) ? r_scnt + 1'b1 : r_scnt;
    assign w_out_free = !r_ov || !i_stall;
    assign w_load     = ((r_st == B_SWR) || (r_st == B_OUT)) && w_out_free;
    assign w_idx_last = ((r_idx + 1'b1) == r_len);
    assign w_rs_addr  = RS_AW'(r_job.slot) * RS_AW'(MAX_ROUTE) + RS_AW'(r_idx);
    assign w_stage_we = (r_st == B_IDLE) && i_jv && (i_job.item.cmd == CMD_FILL)
                        && (r_scnt < SCNT_W'(MAX_ROUTE));
    assign w_commit   = (r_st == B_CWR) && w_idx_last;
    assign w_hit      = r_valid[r_job.slot] && (r_key_q == key_of(r_job.item));
    assign w_filled_new = r_filled + CNT_W'(!r_valid[r_job.slot]);
    assign o_pop      = (r_st == B_IDLE) && i_jv;

    // Slot key and length tables.
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            m_key[r_job.slot] <= key_of(r_job.item);
            m_len[r_job.slot] <= r_len;
        end
        if (r_st == B_IDLE) begin
            r_key_q <= m_key[i_job.slot];
            r_len_q <= m_len[i_job.slot];
        end
    end

    // Route store: read while streaming a hit, written while committing.
    always_ff @(posedge i_clk) begin
        if (r_st == B_CWR) begin
            m_route[w_rs_addr] <= r_stage_q;
        end
        if (r_st == B_SRD) begin
            r_route_q <= m_route[w_rs_addr];
        end
    end

    // Staging buffer for the route being filled.
    always_ff @(posedge i_clk) begin
        if (w_stage_we) begin
            m_stage[r_scnt[RIDX_W-1:0]] <= i_job.item.route_node;
        end
        if (r_st == B_CRD) begin
            r_stage_q <= m_stage[r_idx[RIDX_W-1:0]];
        end
    end

    // Result valid flag: set when a beat is loaded, cleared once it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    // Control sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= B_IDLE;
            r_valid  <= '0;
            r_filled <= '0;
            r_scnt   <= '0;
        end else begin
            case (r_st)
                B_IDLE: begin
                    if (i_jv) begin
                        r_job <= i_job;
                        case (i_job.item.cmd)
                            CMD_CLEAR: begin
                                r_valid  <= '0;
                                r_filled <= '0;
                                r_scnt   <= '0;
                                r_res    <= mk_out('0, '0, ST_CLEARED, 1'b1, '0);
                                r_st     <= B_OUT;
                            end
                            CMD_LOOKUP: begin
                                if (w_bad) begin
                                    r_res <= mk_out('0, '0, ST_INVALID, 1'b1, r_filled);
                                    r_st  <= B_OUT;
                                end else if (w_triv) begin
                                    r_res <= mk_out(i_job.item.start_node, LEN_W'(1),
                                                    ST_TRIVIAL, 1'b1, r_filled);
                                    r_st  <= B_OUT;
                                end else begin
                                    r_st <= B_LOOK;
                                end
                            end
                            CMD_FILL: begin
                                if (!i_job.item.fill_last) begin
                                    r_scnt <= w_scnt_inc;
                                end else begin
                                    r_scnt <= '0;
                                    r_len  <= w_scnt_inc;
                                    r_idx  <= '0;
                                    if (w_bad) begin
                                        r_res <= mk_out('0, '0, ST_INVALID, 1'b1, r_filled);
                                        r_st  <= B_OUT;
                                    end else if (w_triv) begin
                                        r_res <= mk_out(i_job.item.start_node, LEN_W'(1),
                                                        ST_TRIVIAL, 1'b1, r_filled);
                                        r_st  <= B_OUT;
                                    end else if (w_scnt_inc > SCNT_W'(MAX_ROUTE)) begin
                                        r_res <= mk_out('0, '0, ST_TOO_LONG, 1'b1, r_filled);
                                        r_st  <= B_OUT;
                                    end else begin
                                        r_st <= B_CRD;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                B_LOOK: begin
                    if (w_hit) begin
                        r_len <= r_len_q;
                        r_idx <= '0;
                        r_st  <= B_SRD;
                    end else begin
                        r_res <= mk_out('0, '0, ST_MISS, 1'b1, r_filled);
                        r_st  <= B_OUT;
                    end
                end
                B_SRD: begin
                    r_st <= B_SWR;
                end
                B_SWR: begin
                    if (w_out_free) begin
                        r_out <= mk_out(r_route_q, LEN_W'(r_len), ST_HIT, w_idx_last, r_filled);
                        if (w_idx_last) begin
                            r_st <= B_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                            r_st  <= B_SRD;
                        end
                    end
                end
                B_CRD: begin
                    r_st <= B_CWR;
                end
                B_CWR: begin
                    if (w_idx_last) begin
                        r_valid[r_job.slot] <= 1'b1;
                        r_filled <= w_filled_new;
                        r_res <= mk_out('0, LEN_W'(r_len), ST_STORED, 1'b1, w_filled_new);
                        r_st  <= B_OUT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_st  <= B_CRD;
                    end
                end
                B_OUT: begin
                    if (w_out_free) begin
                        r_out <= r_res;
                        r_st  <= B_IDLE;
                    end
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

@@ rtl/hashed_route_cache_unit.sv @@
// ============================================================================
// hashed_route_cache_unit: direct-mapped route cache with golden-ratio hash
// Top level: front hash stage, two-entry queue and execution stage.
// ============================================================================
// Input beats (lookup, fill node, clear) arrive on i_valid / o_stall with the
// payload in i_data; results leave on o_valid / i_stall in o_data.
// The front takes a beat, forms the hash in states M0, M1 and M2 with a
// single shared 32x32 multiplier, then holds the beat until it is queued.
// The back pops a queued item while idle. A lookup that hits reads each
// stored node from the route store port in B_SRD and loads it into the
// result register in B_SWR; a trivial or invalid lookup gives its one
// result from B_OUT, a miss via B_LOOK first. A committing fill copies each
// staged node from staging buffer to route store, then returns one result.
// A fill node that is not the last gives no result; a clear gives one.
// Reset empties every slot at once through the slot valid flags; no sweep.
// When the receiver stalls, the result register holds its beat and the back
// waits; the queue then fills and the front raises o_stall.
// ============================================================================
module hashed_route_cache_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  hrc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output hrc_pkg::t_out o_data
);
    import hrc_pkg::*;

    logic w_push;
    logic w_full;
    logic w_jv;
    logic w_pop;
    t_job w_fjob;
    t_job w_qjob;

    hrc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_job   (w_fjob)
    );

    hrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .o_full  (w_full),
        .o_valid (w_jv),
        .i_pop   (w_pop),
        .o_job   (w_qjob)
    );

    hrc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_jv    (w_jv),
        .i_job   (w_qjob),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // The slot count can never exceed the number of slots.
    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.entries_in_use <= CNT_W'(SLOTS)))
        else $error("entries_in_use above slot count");

    // A clear result reports an empty cache.
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_CLEARED) |-> (o_data.entries_in_use == '0))
        else $error("clear result with slots in use");

    // Only hit beats may leave the last mark low.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status != ST_HIT) |-> o_data.last)
        else $error("non-hit result without last");

    // A miss carries neither node nor length.
    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == ST_MISS)
        |-> (o_data.out_node == '0 && o_data.route_length == '0))
        else $error("miss result carries data");

endmodule

@@ tb/hashed_route_cache_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hashed_route_cache_unit_tb: self-checking bench for the hashed route cache
// Sends lookup, fill and clear beats through the valid/stall input channel.
// A predictor of the cache works out the expected result beats, and a
// monitor checks each result beat against the oldest expected one.
// ============================================================================
module hashed_route_cache_unit_tb;
    import hrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_in   i_data;
    logic  o_valid;
    logic  i_stall;
    t_out  o_data;

    hashed_route_cache_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Predicted cache contents.
    logic [63:0]       pred_keys [SLOTS];
    logic [LEN_W-1:0]  pred_lens [SLOTS];
    logic [31:0]       pred_route [SLOTS * MAX_ROUTE];
    logic [31:0]       pred_staged [MAX_ROUTE];
    int unsigned       pred_stage_cnt;
    int unsigned       pred_filled;

    t_out  expected_beats [$];
    int    error_count;
    int    beats_sent;
    int    beats_checked;
    int    idle_cycles;
    bit    hold_receiver;
    bit    hold_active;

    // Known-key pool so that lookups can hit routes filled earlier.
    logic [31:0] pool_start [8];
    logic [31:0] pool_goal [8];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Short gaps mostly, the odd long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int slot_of(input logic [63:0] key);
        logic [63:0] prod;
        prod = key * 64'h9e3779b97f4a7c15;
        return int'(prod[63:50]) & (SLOTS - 1);
    endfunction

    function automatic t_out beat_of(input logic [31:0] node, input int len,
                                     input logic [2:0] st, input logic lst);
        t_out b;
        b.out_node       = node;
        b.route_length   = len[LEN_W-1:0];
        b.status         = st;
        b.last           = lst;
        b.entries_in_use = pred_filled[CNT_W-1:0];
        return b;
    endfunction

    // Append one expected beat at the tail of the queue.
    task automatic queue_expected(input t_out b);
        expected_beats.insert(expected_beats.size(), b);
    endtask

    task automatic cache_clear_state();
        for (int s = 0; s < SLOTS; s++) begin
            pred_keys[s] = '0;
            pred_lens[s] = '0;
        end
        pred_stage_cnt = 0;
        pred_filled    = 0;
    endtask

    // Work out the result beats that one accepted beat causes.
    task automatic predict_cache(input t_in it);
        logic [63:0] key;
        int slot;
        int len;
        key  = {it.start_node[30:0], it.goal_node, it.car};
        slot = slot_of(key);
        if (it.cmd == CMD_CLEAR) begin
            cache_clear_state();
            queue_expected(beat_of('0, 0, ST_CLEARED, 1'b1));
        end else if (it.cmd == CMD_LOOKUP) begin
            if (it.start_node == NO_NODE || it.goal_node == NO_NODE) begin
                queue_expected(beat_of('0, 0, ST_INVALID, 1'b1));
            end else if (it.start_node == it.goal_node) begin
                queue_expected(beat_of(it.start_node, 1, ST_TRIVIAL, 1'b1));
            end else if (pred_lens[slot] != 0 && pred_keys[slot] == key) begin
                len = pred_lens[slot];
                for (int i = 0; i < len; i++)
                    queue_expected(beat_of(pred_route[slot * MAX_ROUTE + i],
                                           len, ST_HIT, i == len - 1));
            end else begin
                queue_expected(beat_of('0, 0, ST_MISS, 1'b1));
            end
        end else if (it.cmd == CMD_FILL) begin
            if (pred_stage_cnt < MAX_ROUTE) pred_staged[pred_stage_cnt] = it.route_node;
            if (pred_stage_cnt <= MAX_ROUTE) pred_stage_cnt++;
            if (it.fill_last) begin
                len = pred_stage_cnt;
                pred_stage_cnt = 0;
                if (it.start_node == NO_NODE || it.goal_node == NO_NODE) begin
                    queue_expected(beat_of('0, 0, ST_INVALID, 1'b1));
                end else if (it.start_node == it.goal_node) begin
                    queue_expected(beat_of(it.start_node, 1, ST_TRIVIAL, 1'b1));
                end else if (len > MAX_ROUTE) begin
                    queue_expected(beat_of('0, 0, ST_TOO_LONG, 1'b1));
                end else begin
                    if (pred_lens[slot] == 0) pred_filled++;
                    pred_keys[slot] = key;
                    pred_lens[slot] = len[LEN_W-1:0];
                    for (int i = 0; i < len; i++)
                        pred_route[slot * MAX_ROUTE + i] = pred_staged[i];
                    queue_expected(beat_of('0, len, ST_STORED, 1'b1));
                end
            end
        end
    endtask

    // Drive one beat and hold it until it is taken; valid goes low between beats.
    task automatic send_beat(input t_in it);
        int gap;
        gap = pick_gap();
        repeat (gap + 1) @(negedge i_clk);
        i_data  <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_cache(it);
        beats_sent++;
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_data  <= '0;
    endtask

    function automatic t_in make_beat(input logic [1:0] c, input logic [31:0] s,
                                      input logic [31:0] g, input logic cr,
                                      input logic [31:0] n, input logic lst);
        t_in it;
        it.cmd = c; it.start_node = s; it.goal_node = g;
        it.car = cr; it.route_node = n; it.fill_last = lst;
        return it;
    endfunction

    // A route of len + 1 nodes, filled one beat at a time.
    task automatic send_route(input logic [31:0] s, input logic [31:0] g,
                              input logic cr, input int len);
        for (int i = 0; i < len; i++)
            send_beat(make_beat(CMD_FILL, $urandom, $urandom, 1'($urandom_range(0, 1)),
                                $urandom, 1'b0));
        send_beat(make_beat(CMD_FILL, s, g, cr, $urandom, 1'b1));
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in %s: got %0h, expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Result monitor and receiver stall.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected result beat", 32'(o_data.status), 32'd0);
            end else begin
                want = expected_beats.pop_front();
                if (o_data.out_node != want.out_node)
                    report_mismatch("out_node", o_data.out_node, want.out_node);
                if (o_data.route_length != want.route_length)
                    report_mismatch("route_length", 32'(o_data.route_length),
                                    32'(want.route_length));
                if (o_data.status != want.status)
                    report_mismatch("status", 32'(o_data.status), 32'(want.status));
                if (o_data.last != want.last)
                    report_mismatch("last", 32'(o_data.last), 32'(want.last));
                if (o_data.entries_in_use != want.entries_in_use)
                    report_mismatch("entries_in_use", 32'(o_data.entries_in_use),
                                    32'(want.entries_in_use));
            end
        end
    end

    initial begin
        int gap;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                i_stall <= 1'b1;
            end else begin
                gap = pick_gap();
                if (gap > 0 && $urandom_range(0, 2) == 0) begin
                    i_stall <= 1'b1;
                    repeat (gap) @(negedge i_clk);
                end
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no accepted beat on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (!hold_active) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d beats outstanding",
                         expected_beats.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic test_directed_lookups();
        send_beat(make_beat(CMD_LOOKUP, NO_NODE, 32'd5, 1'b0, '0, 1'b0));
        send_beat(make_beat(CMD_LOOKUP, 32'd5, NO_NODE, 1'b1, '0, 1'b0));
        send_beat(make_beat(CMD_LOOKUP, 32'd0, 32'd0, 1'b0, '0, 1'b0));
        send_beat(make_beat(CMD_LOOKUP, 32'hffff_fffe, 32'hffff_fffe, 1'b1, '0, 1'b0));
        send_beat(make_beat(CMD_LOOKUP, 32'd0, 32'd1, 1'b1, '0, 1'b0));
        send_beat(make_beat(CMD_SPARE, $urandom, $urandom, 1'b1, $urandom, 1'b1));
    endtask

    task automatic test_directed_fills();
        send_route(32'd1, 32'd2, 1'b0, 0);
        send_beat(make_beat(CMD_LOOKUP, 32'd1, 32'd2, 1'b0, '0, 1'b0));
        send_route(32'h8000_0001, 32'hffff_fffe, 1'b1, MAX_ROUTE - 1);
        send_beat(make_beat(CMD_LOOKUP, 32'h8000_0001, 32'hffff_fffe, 1'b1, '0, 1'b0));
        // Top start bit falls off the key, so this aliases the route above.
        send_beat(make_beat(CMD_LOOKUP, 32'h0000_0001, 32'hffff_fffe, 1'b1, '0, 1'b0));
        send_beat(make_beat(CMD_LOOKUP, 32'h8000_0001, 32'hffff_fffe, 1'b0, '0, 1'b0));
        send_route(32'd7, 32'd9, 1'b0, MAX_ROUTE);
        send_route(NO_NODE, 32'd9, 1'b0, 1);
        send_route(32'd4, 32'd4, 1'b1, 1);
        send_beat(make_beat(CMD_CLEAR, $urandom, $urandom, 1'b0, $urandom, 1'b0));
        send_beat(make_beat(CMD_LOOKUP, 32'd1, 32'd2, 1'b0, '0, 1'b0));
    endtask

    // Receiver holds off while the sender keeps offering beats.
    task automatic test_backpressure();
        hold_active   = 1'b1;
        hold_receiver = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_receiver = 1'b0;
            end
            for (int i = 0; i < 10; i++)
                send_beat(make_beat(CMD_LOOKUP, $urandom, $urandom, 1'b0, '0, 1'b0));
        join
        hold_active = 1'b0;
    endtask

    task automatic test_random_traffic(input int target);
        int r;
        int k;
        for (int i = 0; i < 8; i++) begin
            pool_start[i] = $urandom;
            pool_goal[i]  = $urandom;
        end
        while (beats_sent < target) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 7);
            if (r < 35) begin
                send_route(pool_start[k], pool_goal[k], k[0],
                           ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_ROUTE + 1)
                                                       : $urandom_range(0, 4));
            end else if (r < 75) begin
                send_beat(make_beat(CMD_LOOKUP, pool_start[k], pool_goal[k], k[0],
                                    $urandom, 1'($urandom_range(0, 1))));
            end else if (r < 85) begin
                send_beat(make_beat(CMD_LOOKUP, $urandom, $urandom,
                                    1'($urandom_range(0, 1)),
                                    $urandom, 1'($urandom_range(0, 1))));
            end else if (r < 88) begin
                send_beat(make_beat(CMD_CLEAR, $urandom, $urandom,
                                    1'($urandom_range(0, 1)),
                                    $urandom, 1'($urandom_range(0, 1))));
            end else if (r < 91) begin
                send_beat(make_beat(CMD_SPARE, $urandom, $urandom,
                                    1'($urandom_range(0, 1)),
                                    $urandom, 1'($urandom_range(0, 1))));
            end else begin
                send_beat(make_beat(CMD_LOOKUP, NO_NODE, NO_NODE, 1'b1,
                                    NO_NODE, 1'b1));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        error_count   = 0;
        beats_sent    = 0;
        beats_checked = 0;
        idle_cycles   = 0;
        hold_receiver = 1'b0;
        hold_active   = 1'b0;
        cache_clear_state();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_lookups();
        test_directed_fills();
        test_backpressure();
        test_random_traffic(beats_sent + 80);
        wait_drained();

        $display("Sent %0d input beats and checked %0d result beats, covering", beats_sent,
                 beats_checked);
        $display("hits, misses, trivial, invalid, over-long fills, clears and a long stall.");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hrc_pkg.sv
rtl/hrc_front.sv
rtl/hrc_fifo.sv
rtl/hrc_back.sv
rtl/hashed_route_cache_unit.sv
tb/hashed_route_cache_unit_tb.sv
